// ----- src/ppdc_pkg.sv -----
// ----------------------------------------------------------------------------
// Packed pixel depth converter package
// Shared types, register indexes, depth codes and the pixel replication
// function used by the converter core and its submodules.
// ----------------------------------------------------------------------------
package ppdc_pkg;

    localparam int BYTE_W          = 8;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 13;
    localparam int DIM_CMP_W       = 17;
    localparam int MAX_WIDTH_DEF   = 4096;
    localparam int MAX_HEIGHT_DEF  = 4096;

    // Depth codes: log2 of bits per pixel.
    localparam logic [1:0] DEPTH_1BPP = 2'd0;
    localparam logic [1:0] DEPTH_2BPP = 2'd1;
    localparam logic [1:0] DEPTH_4BPP = 2'd2;
    localparam logic [1:0] DEPTH_8BPP = 2'd3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SRC_DEPTH = 3'd0,
        CFG_DST_DEPTH = 3'd1,
        CFG_SRC_START = 3'd2,
        CFG_DST_START = 3'd3,
        CFG_ROW_WIDTH = 3'd4,
        CFG_ROW_COUNT = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [1:0] src_shift;
        logic [1:0] dst_shift;
        logic [2:0] src_start;
        logic [2:0] dst_start;
    } t_cfg_fmt;

    typedef struct packed {
        logic [BYTE_W-1:0] dst_byte;
        logic [BYTE_W-1:0] write_mask;
        logic              row_end;
        logic              frame_end;
        logic              last_of_run;
    } t_dst_item;

    // Takes a pixel held in the top bits of a byte and repeats it until the
    // whole byte is filled. The top bits of the result are the pixel at any
    // deeper depth, and truncation to a shallower depth keeps its top bits.
    function automatic logic [BYTE_W-1:0] rep_pixel(input logic [BYTE_W-1:0] aligned,
                                                    input logic [1:0] shift);
        logic [BYTE_W-1:0] res;
        case (shift)
            DEPTH_1BPP: begin
                res = {8{aligned[7]}};
            end
            DEPTH_2BPP: begin
                res = {4{aligned[7:6]}};
            end
            DEPTH_4BPP: begin
                res = {2{aligned[7:4]}};
            end
            default: begin
                res = aligned;
            end
        endcase
        return res;
    endfunction

endpackage

// ----- src/ppdc_if.sv -----
// ----------------------------------------------------------------------------
// Packed pixel depth converter stream interfaces
// Valid/ready channels for source bytes and for destination byte results.
// ----------------------------------------------------------------------------
interface ppdc_src_if;
    logic                           valid;
    logic                           ready;
    logic [ppdc_pkg::BYTE_W-1:0]    src_byte;

    modport source (output valid, output src_byte, input ready);
    modport sink   (input valid, input src_byte, output ready);
endinterface

interface ppdc_dst_if;
    logic                           valid;
    logic                           ready;
    logic [ppdc_pkg::BYTE_W-1:0]    dst_byte;
    logic [ppdc_pkg::BYTE_W-1:0]    write_mask;
    logic                           row_end;
    logic                           frame_end;
    logic                           last_of_run;

    modport source (output valid, output dst_byte, output write_mask, output row_end,
                    output frame_end, output last_of_run, input ready);
    modport sink   (input valid, input dst_byte, input write_mask, input row_end,
                    input frame_end, input last_of_run, output ready);
endinterface

// ----- src/packed_pixel_depth_converter_core.sv -----
// ----------------------------------------------------------------------------
// Packed pixel depth converter core
// Repacks a stream of packed source bytes at 1, 2, 4 or 8 bits per pixel into
// destination bytes of another depth, with write masks and row/frame flags.
//
//   Channel   Direction  Transfer unit         Payload
//   i_src     in         one source byte       src_byte
//   o_dst     out        one destination byte  dst_byte, write_mask, row_end,
//                                              frame_end, last_of_run
//   i_cfg_*   in         one register write    index, data (13 bits)
//
// A source byte is worked off in repacking runs, one run per cycle while the
// result channel does not stall: one run for each destination byte it produces,
// plus one run if its last pixels only partly fill a destination byte.
// A byte that produces no result still takes one run.
// The next source byte is taken in the cycle the current one finishes.
// Reset is synchronous; all registers but the source byte and result data reset.
// A stalled result channel holds the engine; one result waits in the output
// register while the engine prepares the next.
// ----------------------------------------------------------------------------
module packed_pixel_depth_converter_core #(
    parameter int MAX_WIDTH  = ppdc_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = ppdc_pkg::MAX_HEIGHT_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [ppdc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [ppdc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    ppdc_src_if.sink                            i_src,
    ppdc_dst_if.source                          o_dst
);

    localparam int PW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);

    ppdc_pkg::t_cfg_fmt     fmt;
    logic [PW-1:0]          width;
    logic [HW-1:0]          count;
    logic                   res_valid;
    logic                   res_ready;
    ppdc_pkg::t_dst_item    res;

    ppdc_cfg #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_fmt       (fmt),
        .o_width     (width),
        .o_count     (count)
    );

    ppdc_engine #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fmt       (fmt),
        .i_width     (width),
        .i_count     (count),
        .i_in_valid  (i_src.valid),
        .o_in_ready  (i_src.ready),
        .i_in_byte   (i_src.src_byte),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    ppdc_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (res_valid),
        .o_ready (res_ready),
        .i_item  (res),
        .o_dst   (o_dst)
    );

endmodule

// ----- src/ppdc_cfg.sv -----
// ----------------------------------------------------------------------------
// Packed pixel depth converter configuration registers
// Holds the format registers and the clipped row width and row count.
// ----------------------------------------------------------------------------
module ppdc_cfg #(
    parameter int MAX_WIDTH  = ppdc_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = ppdc_pkg::MAX_HEIGHT_DEF,
    localparam int PW = $clog2(MAX_WIDTH + 1),
    localparam int HW = $clog2(MAX_HEIGHT + 1)
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [ppdc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [ppdc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output ppdc_pkg::t_cfg_fmt                  o_fmt,
    output logic [PW-1:0]                       o_width,
    output logic [HW-1:0]                       o_count
);

    localparam logic [ppdc_pkg::DIM_CMP_W-1:0] MW = ppdc_pkg::DIM_CMP_W'(MAX_WIDTH);
    localparam logic [ppdc_pkg::DIM_CMP_W-1:0] MH = ppdc_pkg::DIM_CMP_W'(MAX_HEIGHT);

    ppdc_pkg::t_cfg_fmt                 r_fmt;
    logic [PW-1:0]                      r_width;
    logic [HW-1:0]                      r_count;
    logic [ppdc_pkg::DIM_CMP_W-1:0]     data_ext;
    logic [PW-1:0]                      n_width;
    logic [HW-1:0]                      n_count;

    // A zero dimension counts as one, and anything above the maximum saturates.
    assign data_ext = ppdc_pkg::DIM_CMP_W'(i_cfg_data);

    always_comb begin
        if (data_ext == '0) begin
            n_width = PW'(1);
            n_count = HW'(1);
        end else begin
            n_width = (data_ext > MW) ? PW'(MW) : PW'(data_ext);
            n_count = (data_ext > MH) ? HW'(MH) : HW'(data_ext);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt.src_shift <= ppdc_pkg::DEPTH_1BPP;
            r_fmt.dst_shift <= ppdc_pkg::DEPTH_8BPP;
            r_fmt.src_start <= '0;
            r_fmt.dst_start <= '0;
            r_width         <= PW'(1);
            r_count         <= HW'(1);
        end else if (i_cfg_wr_en) begin
            case (ppdc_pkg::t_cfg_idx'(i_cfg_idx))
                ppdc_pkg::CFG_SRC_DEPTH: begin
                    r_fmt.src_shift <= i_cfg_data[1:0];
                end
                ppdc_pkg::CFG_DST_DEPTH: begin
                    r_fmt.dst_shift <= i_cfg_data[1:0];
                end
                ppdc_pkg::CFG_SRC_START: begin
                    r_fmt.src_start <= i_cfg_data[2:0];
                end
                ppdc_pkg::CFG_DST_START: begin
                    r_fmt.dst_start <= i_cfg_data[2:0];
                end
                ppdc_pkg::CFG_ROW_WIDTH: begin
                    r_width <= n_width;
                end
                ppdc_pkg::CFG_ROW_COUNT: begin
                    r_count <= n_count;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_fmt   = r_fmt;
    assign o_width = r_width;
    assign o_count = r_count;

endmodule

// ----- src/ppdc_engine.sv -----
// ----------------------------------------------------------------------------
// Packed pixel depth converter repacking engine
// Holds one source byte and, each cycle unless a result stalls, moves a run of
// pixels into the destination accumulator through eight parallel pixel lanes,
// ending the run at a full destination byte, the row's end or the byte's end.
// ----------------------------------------------------------------------------
module ppdc_engine #(
    parameter int MAX_WIDTH  = ppdc_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = ppdc_pkg::MAX_HEIGHT_DEF,
    localparam int PW = $clog2(MAX_WIDTH + 1),
    localparam int HW = $clog2(MAX_HEIGHT + 1)
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  ppdc_pkg::t_cfg_fmt              i_fmt,
    input  logic [PW-1:0]                   i_width,
    input  logic [HW-1:0]                   i_count,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [ppdc_pkg::BYTE_W-1:0]     i_in_byte,
    output logic                            o_res_valid,
    input  logic                            i_res_ready,
    output ppdc_pkg::t_dst_item             o_res
);

    logic                           r_busy;
    logic                           r_fresh;
    logic [ppdc_pkg::BYTE_W-1:0]    r_byte;
    logic [3:0]                     r_s;
    logic [2:0]                     r_d;
    logic [ppdc_pkg::BYTE_W-1:0]    r_acc;
    logic [ppdc_pkg::BYTE_W-1:0]    r_macc;
    logic [PW-1:0]                  r_pd;
    logic [HW-1:0]                  r_rd;

    logic [3:0]                     sppb;
    logic [3:0]                     dppb;
    logic [3:0]                     dbits;
    logic [ppdc_pkg::BYTE_W-1:0]    top_mask;
    logic                           pd_zero;
    logic [3:0]                     s_eff;
    logic [2:0]                     d_eff;
    logic [ppdc_pkg::BYTE_W-1:0]    acc_eff;
    logic [ppdc_pkg::BYTE_W-1:0]    macc_eff;
    logic [PW-1:0]                  rem_full;
    logic [PW+3:0]                  rem_ext;
    logic [3:0]                     rem8;
    logic [3:0]                     room_src;
    logic [3:0]                     room_dst;
    logic [3:0]                     k;
    logic                           row_done;
    logic                           dst_full;
    logic                           byte_done;
    logic                           emit;
    logic                           more;
    logic [3:0]                     src_left;
    logic [3:0]                     rem_after;
    logic [HW:0]                    rd_inc;
    logic                           frame_done;
    logic [PW:0]                    pd_sum;
    logic [ppdc_pkg::BYTE_W-1:0]    lane_data;
    logic [ppdc_pkg::BYTE_W-1:0]    lane_mask;
    logic [ppdc_pkg::BYTE_W-1:0]    acc_new;
    logic [ppdc_pkg::BYTE_W-1:0]    macc_new;
    logic                           fire;
    logic                           in_acc;

    assign sppb     = 4'd8 >> i_fmt.src_shift;
    assign dppb     = 4'd8 >> i_fmt.dst_shift;
    assign dbits    = 4'd1 << i_fmt.dst_shift;
    assign top_mask = ~(8'hFF >> dbits);

    // A byte that arrives with no pixels done in the row opens a new row.
    assign pd_zero  = (r_pd == '0);
    assign s_eff    = r_fresh ? (pd_zero ? {1'b0, i_fmt.src_start & (sppb[2:0] - 3'd1)} : 4'd0)
                              : r_s;
    assign d_eff    = pd_zero ? (i_fmt.dst_start & (dppb[2:0] - 3'd1))
                              : (r_d & (dppb[2:0] - 3'd1));
    assign acc_eff  = pd_zero ? '0 : r_acc;
    assign macc_eff = pd_zero ? '0 : r_macc;

    // Pixels left in the row, saturated at fifteen; a count already at or past the
    // width ends the row on the next pixel.
    assign rem_full = i_width - r_pd;
    assign rem_ext  = (PW + 4)'(rem_full);
    always_comb begin
        if (r_pd >= i_width) begin
            rem8 = 4'd1;
        end else if (rem_ext > (PW + 4)'(15)) begin
            rem8 = 4'd15;
        end else begin
            rem8 = rem_ext[3:0];
        end
    end

    assign room_src = sppb - s_eff;
    assign room_dst = dppb - {1'b0, d_eff};

    always_comb begin
        k = room_src;
        if (room_dst < k) begin
            k = room_dst;
        end
        if (rem8 < k) begin
            k = rem8;
        end
    end

    assign row_done  = (k == rem8);
    assign dst_full  = (({1'b0, d_eff} + k) == dppb);
    assign byte_done = ((s_eff + k) == sppb) || row_done;
    assign emit      = row_done || dst_full;

    // After an early result the next run starts on a fresh destination byte,
    // so a further result follows if the byte still fills one or ends the row.
    assign src_left  = sppb - (s_eff + k);
    assign rem_after = rem8 - k;
    assign more      = !byte_done && ((src_left >= dppb) || (rem_after <= src_left));

    assign rd_inc     = (HW + 1)'(r_rd) + (HW + 1)'(1);
    assign frame_done = row_done && (rd_inc >= (HW + 1)'(i_count));
    assign pd_sum     = (PW + 1)'(r_pd) + (PW + 1)'(k);

    always_comb begin
        logic [3:0]                     si;
        logic [2:0]                     di;
        logic [ppdc_pkg::BYTE_W-1:0]    aligned;
        logic [ppdc_pkg::BYTE_W-1:0]    pix;
        lane_data = '0;
        lane_mask = '0;
        for (int j = 0; j < 8; j++) begin
            si      = s_eff + 4'(j);
            di      = 3'(d_eff + 3'(j));
            aligned = r_byte << (6'(si[2:0]) << i_fmt.src_shift);
            pix     = ppdc_pkg::rep_pixel(aligned, i_fmt.src_shift) & top_mask;
            if (4'(j) < k) begin
                lane_data = lane_data | (pix >> (6'(di) << i_fmt.dst_shift));
                lane_mask = lane_mask | (top_mask >> (6'(di) << i_fmt.dst_shift));
            end
        end
    end

    assign acc_new  = acc_eff | lane_data;
    assign macc_new = macc_eff | lane_mask;

    assign fire       = r_busy && (!emit || i_res_ready);
    assign o_in_ready = !r_busy || (fire && byte_done);
    assign in_acc     = i_in_valid && o_in_ready;

    assign o_res_valid       = r_busy && emit;
    assign o_res.dst_byte    = acc_new;
    assign o_res.write_mask  = macc_new;
    assign o_res.row_end     = row_done;
    assign o_res.frame_end   = frame_done;
    assign o_res.last_of_run = !more;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_fresh <= 1'b0;
            r_s     <= '0;
            r_d     <= '0;
            r_acc   <= '0;
            r_macc  <= '0;
            r_pd    <= '0;
            r_rd    <= '0;
        end else begin
            if (in_acc) begin
                r_busy  <= 1'b1;
                r_fresh <= 1'b1;
            end else if (fire) begin
                r_fresh <= 1'b0;
                if (byte_done) begin
                    r_busy <= 1'b0;
                end
            end
            if (fire) begin
                r_s <= s_eff + k;
                if (emit) begin
                    r_acc  <= '0;
                    r_macc <= '0;
                    r_d    <= '0;
                end else begin
                    r_acc  <= acc_new;
                    r_macc <= macc_new;
                    r_d    <= 3'({1'b0, d_eff} + k);
                end
                if (row_done) begin
                    r_pd <= '0;
                    r_rd <= frame_done ? '0 : HW'(rd_inc);
                end else begin
                    r_pd <= PW'(pd_sum);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_byte <= i_in_byte;
        end
    end

    // Every run moves at least one pixel and never more than a byte holds.
    a_run_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (k != 4'd0) && (k <= 4'd8))
        else $error("repack run length out of range");

    // A run that leaves pixels in the byte must have produced a result.
    a_mid_byte_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && !byte_done) |-> emit)
        else $error("run stopped mid byte without a result");

    // After a mid-byte result the engine carries on with the same byte.
    a_mid_byte_continue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && !byte_done) |=> (r_busy && !r_fresh && (r_s != 4'd0)))
        else $error("engine lost its place in the source byte");

    // The frame can only end where a row ends.
    a_frame_on_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.frame_end) |-> o_res.row_end)
        else $error("frame end without row end");

endmodule

// ----- src/ppdc_out.sv -----
// ----------------------------------------------------------------------------
// Packed pixel depth converter output register
// Registers each destination byte result and presents it on the result
// channel until it is transferred.
// ----------------------------------------------------------------------------
module ppdc_out (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  ppdc_pkg::t_dst_item     i_item,
    ppdc_dst_if.source              o_dst
);

    logic                   r_valid;
    ppdc_pkg::t_dst_item    r_item;

    assign o_ready = !r_valid || o_dst.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

    assign o_dst.valid       = r_valid;
    assign o_dst.dst_byte    = r_item.dst_byte;
    assign o_dst.write_mask  = r_item.write_mask;
    assign o_dst.row_end     = r_item.row_end;
    assign o_dst.frame_end   = r_item.frame_end;
    assign o_dst.last_of_run = r_item.last_of_run;

endmodule
